// ===== hdl/mlcs_pkg.sv =====
`default_nettype none
package mlcs_pkg;

   // default sizes
   localparam int BUFFER_DEPTH_DEF = 16;
   localparam int FRAME_BYTES_DEF  = 10;
   localparam int QUEUE_DEPTH      = 2;

   // register indexes
   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_LIMIT = 2'd1;
   localparam logic [1:0] REG_STEP  = 2'd2;

   localparam logic [15:0] GAIN_RST  = 16'd3277;
   localparam logic [6:0]  LIMIT_RST = 7'd60;
   localparam logic [6:0]  STEP_RST  = 7'd1;

   // operations
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // tick kinds handed from front to back
   localparam logic [1:0] KIND_KEEP     = 2'd0;
   localparam logic [1:0] KIND_ZERO     = 2'd1;
   localparam logic [1:0] KIND_CENTROID = 2'd2;

   // quotient width of the centroid divide (1280 * 64 < 2**17)
   localparam int DIV_BITS = 17;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [6:0]         forward_speed;
      logic signed [15:0] turn_rate;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] sensors;
   } cmd_type;

   // frame header, bytes 0..4
   function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h52;
         3'd1:    b = 8'h4D;
         3'd2:    b = 8'h67;
         3'd3:    b = 8'h73;
         3'd4:    b = 8'h77;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/mlcs_fifo.sv =====
`default_nettype none
module mlcs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mlcs_front.sv =====
`default_nettype none
module mlcs_front #(
   parameter int BUFFER_DEPTH = mlcs_pkg::BUFFER_DEPTH_DEF,
   parameter int FRAME_BYTES  = mlcs_pkg::FRAME_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire mlcs_pkg::req_type req_data,
   output logic                  cmd_push,
   output mlcs_pkg::cmd_type     cmd_data
);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          hdr_ok_ff, hdr_ok_in;
   logic [7:0]    b5_ff, b6_ff, b7_ff;
   logic          is_byte, is_tick, frame_ready;
   logic [7:0]    rx;

   assign rx          = req_data.rx_byte;
   assign is_byte     = req_valid && (req_data.operation == mlcs_pkg::OP_BYTE);
   assign is_tick     = req_valid && (req_data.operation == mlcs_pkg::OP_TICK);
   assign frame_ready = (count_ff >= CW'(FRAME_BYTES));

   // byte count and running header match
   always_comb begin
      count_in  = count_ff;
      hdr_ok_in = hdr_ok_ff;
      if (is_byte && (count_ff < CW'(BUFFER_DEPTH))) begin
         if (count_ff == '0) begin
            // a frame only starts on the first header byte
            count_in  = (rx == mlcs_pkg::hdr_byte(3'd0)) ? CW'(1) : '0;
            hdr_ok_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff < CW'(5)) begin
               hdr_ok_in = hdr_ok_ff && (rx == mlcs_pkg::hdr_byte(count_ff[2:0]));
            end
         end
      end else if (is_tick && frame_ready) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // header flag and sensor bytes
   always_ff @(posedge clock) begin
      hdr_ok_ff <= hdr_ok_in;
      if (is_byte && (count_ff == CW'(5))) begin
         b5_ff <= rx;
      end
      if (is_byte && (count_ff == CW'(6))) begin
         b6_ff <= rx;
      end
      if (is_byte && (count_ff == CW'(7))) begin
         b7_ff <= rx;
      end
   end

   // classify the tick for the back end
   always_comb begin
      cmd_push         = is_tick;
      cmd_data.sensors = {b7_ff[0], b6_ff, b5_ff[7:1]};
      cmd_data.kind    = mlcs_pkg::KIND_KEEP;
      if (frame_ready && hdr_ok_ff) begin
         if ((b5_ff | b6_ff | b7_ff) == 8'd0) begin
            cmd_data.kind = mlcs_pkg::KIND_ZERO;
         end else begin
            cmd_data.kind = mlcs_pkg::KIND_CENTROID;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mlcs_back.sv =====
`default_nettype none
module mlcs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              cmd_empty,
   input  wire mlcs_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output mlcs_pkg::rsp_type      rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   localparam int DB = mlcs_pkg::DIV_BITS;
   localparam int SW = $clog2(DB);

   logic [2:0]          state_ff, state_in;
   logic [15:0]         word_ff, word_in;
   logic [3:0]          idx_ff, idx_in;
   logic signed [7:0]   sum_ff, sum_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [DB-1:0]       divd_ff, divd_in;
   logic [3:0]          rem_ff, rem_in;
   logic [SW-1:0]       step_ff, step_in;
   logic signed [15:0]  station_ff, station_in;
   logic signed [32:0]  prod_ff, prod_in;
   logic [6:0]          speed_ff, speed_in;
   logic [15:0]         gain_ff;
   logic [6:0]          limit_ff, stepsz_ff;

   logic signed [7:0]   weight;
   logic [7:0]          mag;
   logic [4:0]          trial;
   logic                qbit;
   logic [DB-1:0]       quot;
   logic [7:0]          ramp;

   assign weight = $signed({3'b000, idx_ff, 1'b0}) - 8'sd15;
   assign mag    = sum_ff[7] ? 8'(-sum_ff) : 8'(sum_ff);
   assign trial  = {rem_ff, divd_ff[DB-1]};
   assign qbit   = (trial >= cnt_ff);
   assign quot   = {divd_ff[DB-2:0], qbit};
   assign ramp   = {1'b0, speed_ff} + {1'b0, stepsz_ff};

   assign rsp_data.forward_speed = speed_ff;
   assign rsp_data.turn_rate     = prod_ff[31:16];

   // sequencer: scan sensors and divide for a new centroid, scale by gain, emit
   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      divd_in    = divd_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      station_in = station_ff;
      prod_in    = prod_ff;
      speed_in   = speed_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_data.kind)
                  mlcs_pkg::KIND_ZERO: begin
                     station_in = '0;
                     speed_in   = '0;
                     state_in   = ST_MUL;
                  end
                  mlcs_pkg::KIND_CENTROID: begin
                     word_in  = cmd_data.sensors;
                     idx_in   = '0;
                     sum_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one sensor per cycle, lowest index first
            if (word_ff[0]) begin
               sum_in = sum_ff + weight;
               cnt_in = cnt_ff + 1'b1;
            end
            word_in = {1'b0, word_ff[15:1]};
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == 4'd15) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (cnt_ff == '0) begin
               // only unused bits set
               station_in = '0;
               state_in   = ST_MUL;
            end else begin
               neg_in   = sum_ff[7];
               divd_in  = (DB'(mag[6:0]) << 10) + (DB'(mag[6:0]) << 8);
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in  = qbit ? 4'(trial - cnt_ff) : trial[3:0];
            divd_in = quot;
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(DB - 1)) begin
               station_in = neg_ff ? -$signed(quot[15:0]) : $signed(quot[15:0]);
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = station_ff * $signed({1'b0, gain_ff});
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (speed_ff < limit_ff) begin
                  speed_in = ramp[7] ? 7'd127 : ramp[6:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         station_ff <= '0;
         speed_ff   <= '0;
         gain_ff    <= mlcs_pkg::GAIN_RST;
         limit_ff   <= mlcs_pkg::LIMIT_RST;
         stepsz_ff  <= mlcs_pkg::STEP_RST;
      end else begin
         state_ff   <= state_in;
         station_ff <= station_in;
         speed_ff   <= speed_in;
         if (csr_we) begin
            case (csr_index)
               mlcs_pkg::REG_GAIN:  gain_ff   <= csr_wdata;
               mlcs_pkg::REG_LIMIT: limit_ff  <= csr_wdata[6:0];
               mlcs_pkg::REG_STEP:  stepsz_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      divd_ff <= divd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

// ===== hdl/mag_line_centroid_steer_core.sv =====
// Received bytes give no result; full stays low unless the tick queue fills.
// A control tick gives one result. A kept station or a zero frame goes straight to multiply
// and emit; a frame with only unused sensor bits set first takes the scan and prep; a new
// centroid takes the 16-sensor scan, prep, 17-bit divide, multiply and emit; a full result queue holds the emit.
// The sequencer sets tick throughput, one tick at a time; a 2-entry queue decouples it from input.
// Synchronous active-high reset clears counts, station, speed, queues and loads register defaults.
`default_nettype none
module mag_line_centroid_steer_core #(
   parameter int BUFFER_DEPTH = mlcs_pkg::BUFFER_DEPTH_DEF,
   parameter int FRAME_BYTES  = mlcs_pkg::FRAME_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire mlcs_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output mlcs_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   localparam int CMD_W = $bits(mlcs_pkg::cmd_type);
   localparam int RSP_W = $bits(mlcs_pkg::rsp_type);

   logic              accept;
   logic              cmd_push, cmd_pop, cmd_empty;
   mlcs_pkg::cmd_type cmd_wr, cmd_rd;
   logic              rsp_push, rsp_full;
   mlcs_pkg::rsp_type rsp_wr;

   assign accept = push && !full;

   // byte collection and tick classification
   mlcs_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .FRAME_BYTES  (FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (accept),
      .req_data  (req_data),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wr)
   );

   // tick queue
   mlcs_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (mlcs_pkg::QUEUE_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   // centroid, steering and speed ramp
   mlcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   // result queue
   mlcs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mlcs_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule
`default_nettype wire

// ===== bench/tb_mag_line_centroid_steer_core.sv =====
`timescale 1ns / 100ps
module tb_mag_line_centroid_steer_core;

   localparam int          LIMIT_CYCLES  = 500000;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          NUM_PHASES    = 8;
   localparam int          RANDOM_ITEMS  = 1120;
   localparam logic [39:0] FRAME_HEAD    = 40'h52_4D_67_73_77;
   localparam logic [7:0]  HEAD_FIRST    = 8'h52;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              push      = 1'b0;
   logic              full;
   mlcs_pkg::req_type req_data  = '0;
   logic              empty;
   logic              pop       = 1'b0;
   mlcs_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic [1:0]        csr_index = mlcs_pkg::REG_GAIN;
   logic [15:0]       csr_wdata = '0;

   // stimulus waiting for the driver, steering results waiting for the DUT
   mlcs_pkg::req_type stim_q[$];
   mlcs_pkg::rsp_type steer_due[$];
   int                queued      = 0;
   int                mismatches  = 0;
   int unsigned       cycles      = 0;
   int unsigned       drv_gap_max = 4;
   int unsigned       mon_gap_max = 4;
   int unsigned       drv_wait    = 0;
   int unsigned       mon_wait    = 0;

   // predictor state and register copies
   logic [7:0]         frame_mem [mlcs_pkg::BUFFER_DEPTH_DEF];
   int unsigned        held     = 0;
   logic signed [15:0] station  = '0;
   logic [6:0]         speed    = '0;
   logic [15:0]        gain     = mlcs_pkg::GAIN_RST;
   logic [6:0]         limit    = mlcs_pkg::LIMIT_RST;
   logic [6:0]         step     = mlcs_pkg::STEP_RST;

   mag_line_centroid_steer_core dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      mismatches++;
   endtask

   // station in Q8.8: 10 * mean weight (i - 7.5) of the set sensors, toward zero
   function automatic logic signed [15:0] centroid_station(input logic [23:0] sens_bytes);
      logic [15:0] s;
      int          sum2;
      int          n;
      s    = {sens_bytes[0], sens_bytes[15:8], sens_bytes[23:17]};
      sum2 = 0;
      n    = 0;
      for (int i = 0; i < 16; i++) begin
         if (s[i]) begin
            sum2 += 2 * i - 15;
            n++;
         end
      end
      if (n == 0) return '0;
      return 16'((1280 * sum2) / n);
   endfunction

   // advance the steering state by one accepted transaction
   task automatic predict_steering(input mlcs_pkg::req_type item);
      mlcs_pkg::rsp_type res;
      longint            st;
      longint            g;
      longint            prod;
      int unsigned       nxt;
      if (item.operation == mlcs_pkg::OP_BYTE) begin
         if (held < mlcs_pkg::BUFFER_DEPTH_DEF) begin
            frame_mem[held] = item.rx_byte;
            held++;
            if (frame_mem[0] != HEAD_FIRST) held = 0;
         end
      end else begin
         if (held >= mlcs_pkg::FRAME_BYTES_DEF) begin
            if ({frame_mem[0], frame_mem[1], frame_mem[2], frame_mem[3], frame_mem[4]}
                == FRAME_HEAD) begin
               if ({frame_mem[5], frame_mem[6], frame_mem[7]} == 24'd0) begin
                  speed   = '0;
                  station = '0;
               end else begin
                  station = centroid_station({frame_mem[5], frame_mem[6], frame_mem[7]});
               end
            end
            held = 0;
         end
         st   = station;
         g    = gain;
         prod = st * g;
         res.forward_speed = speed;
         res.turn_rate     = 16'(prod >>> 16);
         steer_due.push_back(res);
         if (speed < limit) begin
            nxt   = speed + step;
            speed = (nxt > 127) ? 7'd127 : 7'(nxt);
         end
      end
   endtask

   // driver: one transaction per item, random gap after each
   always @(posedge clock) begin
      if (reset) begin
         push     <= 1'b0;
         drv_wait  = 0;
      end else begin
         if (push && !full) predict_steering(req_data);
         if (push && full) begin
            // hold the transaction until accepted
         end else if (drv_wait > 0) begin
            push     <= 1'b0;
            drv_wait  = drv_wait - 1;
         end else if (stim_q.size() != 0) begin
            req_data <= stim_q.pop_front();
            push     <= 1'b1;
            drv_wait  = $urandom_range(0, drv_gap_max);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // monitor: compare each popped result against the oldest prediction
   always @(posedge clock) begin
      mlcs_pkg::rsp_type want;
      if (reset) begin
         pop      <= 1'b0;
         mon_wait  = 0;
      end else begin
         if (pop && !empty) begin
            if (steer_due.size() == 0) begin
               report_mismatch("unrequested result, turn_rate", rsp_data.turn_rate, 0);
            end else begin
               want = steer_due.pop_front();
               if (rsp_data.forward_speed !== want.forward_speed)
                  report_mismatch("forward_speed", rsp_data.forward_speed, want.forward_speed);
               if (rsp_data.turn_rate !== want.turn_rate)
                  report_mismatch("turn_rate", rsp_data.turn_rate, want.turn_rate);
            end
            mon_wait = $urandom_range(0, mon_gap_max);
         end
         if (mon_wait > 0) begin
            pop      <= 1'b0;
            mon_wait  = mon_wait - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic add_item(input logic op, input logic [7:0] b);
      mlcs_pkg::req_type it;
      it.operation = op;
      it.rx_byte   = b;
      stim_q.push_back(it);
      queued++;
   endtask

   // header, three sensor bytes, two spare bytes, extra trailing bytes, tick;
   // optional corrupted header byte and an early tick after split bytes
   task automatic add_frame(input logic [23:0] sens, input int extra, input int head_fault,
                            input int split);
      logic [7:0] seq [$];
      logic [7:0] flip;
      for (int i = 4; i >= 0; i--) seq.push_back(FRAME_HEAD[i*8 +: 8]);
      seq.push_back(sens[23:16]);
      seq.push_back(sens[15:8]);
      seq.push_back(sens[7:0]);
      for (int i = 0; i < 2 + extra; i++) seq.push_back(8'($urandom));
      if (head_fault > 0) begin
         flip           = 8'($urandom_range(1, 255));
         seq[head_fault] = seq[head_fault] ^ flip;
      end
      foreach (seq[i]) begin
         if (split > 0 && i == split) add_item(mlcs_pkg::OP_TICK, 8'($urandom));
         add_item(mlcs_pkg::OP_BYTE, seq[i]);
      end
      add_item(mlcs_pkg::OP_TICK, 8'($urandom));
   endtask

   // place a 16-sensor pattern into bytes 5..7, unused bits random
   function automatic logic [23:0] place_sensors(input logic [15:0] s);
      logic [23:0] w;
      w        = 24'($urandom);
      w[23:17] = s[6:0];
      w[15:8]  = s[14:7];
      w[0]     = s[15];
      return w;
   endfunction

   function automatic logic [23:0] pick_sensors();
      logic [23:0] w;
      logic [15:0] s;
      int          lo;
      int          hi;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: begin
            // only the unused bits set
            w       = '0;
            w[16]   = 1'($urandom);
            w[7:1]  = 7'($urandom);
            if (w == '0) w[16] = 1'b1;
         end
         2: begin
            s = '0;
            s[$urandom_range(0, 15)] = 1'b1;
            w = place_sensors(s);
         end
         3: begin
            lo = $urandom_range(0, 15);
            hi = $urandom_range(lo, 15);
            s  = '0;
            for (int i = lo; i <= hi; i++) s[i] = 1'b1;
            w = place_sensors(s);
         end
         default: w = 24'($urandom);
      endcase
      return w;
   endfunction

   function automatic int pick_extra();
      if ($urandom_range(0, 9) == 0) return $urandom_range(6, 9);
      return $urandom_range(0, 3);
   endfunction

   task automatic add_random_sequence();
      int         r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         add_frame(pick_sensors(), pick_extra(), 0, 0);
         if ($urandom_range(0, 4) == 0) add_item(mlcs_pkg::OP_TICK, 8'($urandom));
      end else if (r < 75) begin
         add_frame(pick_sensors(), pick_extra(), $urandom_range(1, 4), 0);
      end else if (r < 85) begin
         add_frame(pick_sensors(), pick_extra(), 0, $urandom_range(1, 9));
      end else begin
         // stray bytes that never start a frame
         repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == HEAD_FIRST) b = ~b;
            add_item(mlcs_pkg::OP_BYTE, b);
         end
         add_item(mlcs_pkg::OP_TICK, 8'($urandom));
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         mlcs_pkg::REG_GAIN:  gain  = val;
         mlcs_pkg::REG_LIMIT: limit = val[6:0];
         mlcs_pkg::REG_STEP:  step  = val[6:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until all transactions are in and all results are out
   task automatic settle();
      @(negedge clock);
      while (stim_q.size() != 0 || push || steer_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: ;
            1: begin
               write_reg(mlcs_pkg::REG_GAIN, 16'hFFFF);
               write_reg(mlcs_pkg::REG_LIMIT, 16'd127);
               write_reg(mlcs_pkg::REG_STEP, 16'd127);
            end
            2: begin
               write_reg(mlcs_pkg::REG_GAIN, 16'd0);
               write_reg(mlcs_pkg::REG_LIMIT, 16'd0);
               write_reg(mlcs_pkg::REG_STEP, 16'd0);
            end
            3: begin
               write_reg(mlcs_pkg::REG_GAIN, 16'd1);
               write_reg(mlcs_pkg::REG_LIMIT, 16'd127);
               write_reg(mlcs_pkg::REG_STEP, 16'd1);
            end
            default: begin
               write_reg(mlcs_pkg::REG_GAIN, 16'($urandom));
               write_reg(mlcs_pkg::REG_LIMIT, 16'($urandom_range(0, 127)));
               write_reg(mlcs_pkg::REG_STEP, 16'($urandom_range(0, 127)));
            end
         endcase
         // every third phase runs without idling on either side
         drv_gap_max = (p % 3 == 1) ? 0 : 4;
         mon_gap_max = (p % 3 == 1) ? 0 : 4;

         if (p == 0) begin
            // tick on an empty buffer, a stray byte, an overflowing frame with
            // all sensors set, then a zero frame
            add_item(mlcs_pkg::OP_TICK, 8'hFF);
            add_item(mlcs_pkg::OP_BYTE, 8'h00);
            add_frame(24'hFFFFFF, 7, 0, 0);
            add_frame(24'h000000, 0, 0, 0);
         end
         target = queued + RANDOM_ITEMS / NUM_PHASES;
         while (queued < target) add_random_sequence();
         settle();
      end

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/mlcs_pkg.sv
hdl/mlcs_fifo.sv
hdl/mlcs_front.sv
hdl/mlcs_back.sv
hdl/mag_line_centroid_steer_core.sv
bench/tb_mag_line_centroid_steer_core.sv
